// ===== rtl/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg
// shared types, token codes and lookup functions of the script token scanner
// ----------------------------------------------------------------------------
package sts_pkg;

   localparam int WORD_BUF_LEN_DEF = 9;
   localparam int COL_BITS_DEF     = 12;
   localparam int ROW_BITS_DEF     = 16;
   localparam int KW_MAX_LEN       = 9;
   localparam int KW_COUNT         = 17;

   // token kinds
   localparam logic [3:0] K_ID   = 4'd0;
   localparam logic [3:0] K_KW   = 4'd1;
   localparam logic [3:0] K_INT  = 4'd2;
   localparam logic [3:0] K_REAL = 4'd3;
   localparam logic [3:0] K_STR  = 4'd4;
   localparam logic [3:0] K_CHAR = 4'd5;
   localparam logic [3:0] K_SYM  = 4'd6;
   localparam logic [3:0] K_EOF  = 4'd7;
   localparam logic [3:0] K_ERR  = 4'd8;

   // two-character symbol codes
   localparam logic [4:0] S_NONE = 5'd0;
   localparam logic [4:0] S_GE   = 5'd20;
   localparam logic [4:0] S_LE   = 5'd21;
   localparam logic [4:0] S_EQ   = 5'd22;
   localparam logic [4:0] S_NE   = 5'd23;
   localparam logic [4:0] S_AND  = 5'd24;
   localparam logic [4:0] S_OR   = 5'd25;

   // keyword text, right aligned, first character highest
   localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
      72'("function"), 72'("var"), 72'("let"), 72'("const"), 72'("true"),
      72'("false"), 72'("this"), 72'("if"), 72'("else"), 72'("while"),
      72'("return"), 72'("undefined"), 72'("null"), 72'("for"), 72'("break"),
      72'("continue"), 72'("class")
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd8, 4'd3, 4'd3, 4'd5, 4'd4, 4'd5, 4'd4, 4'd2, 4'd4, 4'd5,
      4'd6, 4'd9, 4'd4, 4'd3, 4'd5, 4'd8, 4'd5
   };

   typedef struct packed {
      logic       hit;
      logic [4:0] code;
   } lookup_type;

   // write strobes from the front end into the token queue
   typedef struct packed {
      logic wr0;
      logic wr1;
   } push_type;

   function automatic lookup_type kw_lookup(input logic [KW_MAX_LEN-1:0][7:0] w,
                                            input logic [3:0] n);
      lookup_type r;
      logic       same;
      r.hit  = 1'b0;
      r.code = 5'd0;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         same = (n == KW_LEN[k]);
         for (int i = 0; i < KW_MAX_LEN; i++) begin
            if (4'(i) < KW_LEN[k] &&
                w[i] != KW_TEXT[k][8*(int'(KW_LEN[k]) - 1 - i) +: 8]) begin
               same = 1'b0;
            end
         end
         if (same) begin
            r.hit  = 1'b1;
            r.code = 5'(k);
         end
      end
      return r;
   endfunction

   function automatic lookup_type sym_lookup(input logic [7:0] c);
      lookup_type r;
      r.hit = 1'b1;
      case (c)
         "{": r.code = 5'd0;
         "}": r.code = 5'd1;
         "(": r.code = 5'd2;
         ")": r.code = 5'd3;
         "[": r.code = 5'd4;
         "]": r.code = 5'd5;
         ".": r.code = 5'd6;
         ",": r.code = 5'd7;
         ";": r.code = 5'd8;
         "+": r.code = 5'd9;
         "-": r.code = 5'd10;
         "*": r.code = 5'd11;
         "/": r.code = 5'd12;
         "%": r.code = 5'd13;
         "&": r.code = 5'd14;
         "|": r.code = 5'd15;
         "!": r.code = 5'd16;
         "<": r.code = 5'd17;
         ">": r.code = 5'd18;
         "=": r.code = 5'd19;
         default: begin
            r.hit  = 1'b0;
            r.code = 5'd0;
         end
      endcase
      return r;
   endfunction

   function automatic logic [4:0] pair_code(input logic [7:0] a, input logic [7:0] b);
      logic [4:0] r;
      r = S_NONE;
      if (b == "=") begin
         if (a == ">") r = S_GE;
         else if (a == "<") r = S_LE;
         else if (a == "=") r = S_EQ;
         else if (a == "!") r = S_NE;
      end
      if (a == "&" && b == "&") r = S_AND;
      if (a == "|" && b == "|") r = S_OR;
      return r;
   endfunction

endpackage

// ===== rtl/sts_front.sv =====
// ----------------------------------------------------------------------------
// sts_front
// byte scanner: keeps the scan mode and counters, builds up to two records
// ----------------------------------------------------------------------------
module sts_front
   import sts_pkg::*;
#(
   parameter int WORD_BUF_LEN = WORD_BUF_LEN_DEF,
   parameter int COL_BITS     = COL_BITS_DEF,
   parameter int ROW_BITS     = ROW_BITS_DEF,
   parameter int REC_W        = 4 + 5 + 5 + ROW_BITS + 2 * COL_BITS + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       ch,
   input  logic             at_end,
   output push_type         wr,
   output logic [REC_W-1:0] rec0,
   output logic [REC_W-1:0] rec1
);

   localparam int WB_IDX = $clog2(WORD_BUF_LEN);
   localparam logic [COL_BITS-1:0] COL_MAX = {COL_BITS{1'b1}};
   localparam logic [ROW_BITS-1:0] ROW_MAX = {ROW_BITS{1'b1}};

   localparam logic [2:0] M_IDLE    = 3'd0;
   localparam logic [2:0] M_WORD    = 3'd1;
   localparam logic [2:0] M_NUM     = 3'd2;
   localparam logic [2:0] M_STR     = 3'd3;
   localparam logic [2:0] M_CHOPEN  = 3'd4;
   localparam logic [2:0] M_CHESC   = 3'd5;
   localparam logic [2:0] M_CHCLOSE = 3'd6;
   localparam logic [2:0] M_SYM2    = 3'd7;

   logic [2:0]          mode_ff, mode_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [COL_BITS-1:0] start_ff, start_in;
   logic [COL_BITS-1:0] len_ff, len_in;
   logic [WORD_BUF_LEN-1:0][7:0] wbuf_ff, wbuf_in;
   logic [7:0]          psym_ff, psym_in;
   logic                dot_ff, dot_in;
   logic                bsl_ff, bsl_in;

   logic                e_v, s_v, do_start;
   logic [3:0]          e_kind, s_kind;
   logic [4:0]          e_kw, e_sym, s_sym;
   logic [COL_BITS-1:0] e_start, e_len, s_start, s_len, grown;
   logic [KW_MAX_LEN-1:0][7:0] kw_word;
   logic [3:0]          kw_n;
   lookup_type          kw_hit, psym_hit, ch_hit;
   logic [4:0]          pcode;
   logic                is_alpha, is_digit, is_space;

   always_comb begin
      for (int i = 0; i < KW_MAX_LEN; i++) kw_word[i] = wbuf_ff[i];
   end

   assign kw_n     = (len_ff <= COL_BITS'(KW_MAX_LEN)) ? len_ff[3:0] : 4'd0;
   assign kw_hit   = kw_lookup(kw_word, kw_n);
   assign psym_hit = sym_lookup(psym_ff);
   assign ch_hit   = sym_lookup(ch);
   assign pcode    = pair_code(psym_ff, ch);
   assign is_alpha = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") || ch == "_";
   assign is_digit = ch >= "0" && ch <= "9";
   assign is_space = ch == " " || (ch >= 8'd9 && ch <= 8'd13);
   assign grown    = (len_ff < COL_MAX) ? len_ff + 1'b1 : len_ff;

   always_comb begin
      mode_in  = mode_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      start_in = start_ff;
      len_in   = len_ff;
      wbuf_in  = wbuf_ff;
      psym_in  = psym_ff;
      dot_in   = dot_ff;
      bsl_in   = bsl_ff;
      e_v      = 1'b0;
      e_kind   = K_ID;
      e_kw     = 5'd0;
      e_sym    = 5'd0;
      e_start  = start_ff;
      e_len    = len_ff;
      s_v      = 1'b0;
      s_kind   = K_ERR;
      s_sym    = 5'd0;
      s_start  = col_ff;
      s_len    = COL_BITS'(1);
      do_start = 1'b0;
      if (at_end) begin
         case (mode_ff)
            M_WORD: begin
               e_v    = 1'b1;
               e_kind = kw_hit.hit ? K_KW : K_ID;
               e_kw   = kw_hit.hit ? kw_hit.code : 5'd0;
            end
            M_NUM: begin
               e_v    = 1'b1;
               e_kind = dot_ff ? K_REAL : K_INT;
            end
            M_SYM2: begin
               e_v    = 1'b1;
               e_kind = K_SYM;
               e_sym  = psym_hit.code;
               e_len  = COL_BITS'(1);
            end
            M_STR, M_CHOPEN, M_CHESC, M_CHCLOSE: begin
               e_v    = 1'b1;
               e_kind = K_ERR;
            end
            default: ;
         endcase
         s_v     = 1'b1;
         s_kind  = K_EOF;
         s_len   = '0;
         mode_in = M_IDLE;
         dot_in  = 1'b0;
         bsl_in  = 1'b0;
      end else begin
         case (mode_ff)
            M_WORD: begin
               if (is_alpha || is_digit) begin
                  if (len_ff < COL_BITS'(WORD_BUF_LEN)) wbuf_in[len_ff[WB_IDX-1:0]] = ch;
                  len_in = grown;
               end else begin
                  e_v      = 1'b1;
                  e_kind   = kw_hit.hit ? K_KW : K_ID;
                  e_kw     = kw_hit.hit ? kw_hit.code : 5'd0;
                  do_start = 1'b1;
               end
            end
            M_NUM: begin
               if (is_digit) begin
                  len_in = grown;
               end else if (ch == "." && !dot_ff) begin
                  dot_in = 1'b1;
                  len_in = grown;
               end else begin
                  e_v      = 1'b1;
                  e_kind   = dot_ff ? K_REAL : K_INT;
                  do_start = 1'b1;
               end
            end
            M_STR: begin
               len_in = grown;
               if (bsl_ff) begin
                  bsl_in = 1'b0;
               end else if (ch == "\\") begin
                  bsl_in = 1'b1;
               end else if (ch == "\"") begin
                  e_v     = 1'b1;
                  e_kind  = K_STR;
                  e_len   = grown;
                  mode_in = M_IDLE;
               end
            end
            M_CHOPEN: begin
               len_in  = grown;
               mode_in = (ch == "\\") ? M_CHESC : M_CHCLOSE;
            end
            M_CHESC: begin
               len_in  = grown;
               mode_in = M_CHCLOSE;
            end
            M_CHCLOSE: begin
               len_in  = grown;
               e_v     = 1'b1;
               e_kind  = (ch == "'") ? K_CHAR : K_ERR;
               e_len   = grown;
               mode_in = M_IDLE;
            end
            M_SYM2: begin
               e_v    = 1'b1;
               e_kind = K_SYM;
               if (pcode != S_NONE) begin
                  e_sym   = pcode;
                  e_len   = COL_BITS'(2);
                  mode_in = M_IDLE;
               end else begin
                  e_sym    = psym_hit.code;
                  e_len    = COL_BITS'(1);
                  do_start = 1'b1;
               end
            end
            default: do_start = 1'b1;
         endcase

         if (do_start) begin
            mode_in  = M_IDLE;
            start_in = col_ff;
            len_in   = COL_BITS'(1);
            if (is_space) begin
               len_in = '0;
            end else if (is_alpha) begin
               mode_in    = M_WORD;
               wbuf_in[0] = ch;
            end else if (is_digit) begin
               mode_in = M_NUM;
               dot_in  = 1'b0;
            end else if (ch == "\"") begin
               mode_in = M_STR;
               bsl_in  = 1'b0;
            end else if (ch == "'") begin
               mode_in = M_CHOPEN;
            end else if (ch == "=" || ch == "<" || ch == ">" || ch == "!" ||
                         ch == "&" || ch == "|") begin
               mode_in = M_SYM2;
               psym_in = ch;
            end else begin
               s_v    = 1'b1;
               s_kind = ch_hit.hit ? K_SYM : K_ERR;
               s_sym  = ch_hit.code;
            end
         end

         if (ch == 8'h0a) begin
            if (row_ff < ROW_MAX) row_in = row_ff + 1'b1;
            col_in = '0;
         end else if (col_ff < COL_MAX) begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // first slot holds the closed token when there is one
   assign wr.wr0 = accept && (e_v || s_v);
   assign wr.wr1 = accept && e_v && s_v;
   assign rec0 = e_v ? {e_kind, e_kw, e_sym, row_ff, e_start, e_len, !s_v}
                     : {s_kind, 5'd0, s_sym, row_ff, s_start, s_len, 1'b1};
   assign rec1 = {s_kind, 5'd0, s_sym, row_ff, s_start, s_len, 1'b1};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         row_ff   <= ROW_BITS'(1);
         col_ff   <= '0;
         start_ff <= '0;
         len_ff   <= '0;
         wbuf_ff  <= '0;
         psym_ff  <= '0;
         dot_ff   <= 1'b0;
         bsl_ff   <= 1'b0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         wbuf_ff  <= wbuf_in;
         psym_ff  <= psym_in;
         dot_ff   <= dot_in;
         bsl_ff   <= bsl_in;
      end
   end

endmodule

// ===== rtl/sts_queue.sv =====
// ----------------------------------------------------------------------------
// sts_queue
// token record queue: takes up to two records a cycle, hands out one
// ----------------------------------------------------------------------------
module sts_queue
   import sts_pkg::*;
#(
   parameter int REC_W = 4 + 5 + 5 + ROW_BITS_DEF + 2 * COL_BITS_DEF + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  push_type         wr,
   input  logic [REC_W-1:0] rec0,
   input  logic [REC_W-1:0] rec1,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output logic [REC_W-1:0] head
);

   logic [REC_W-1:0] mem_ff [4];
   logic [1:0]       wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic             take;

   assign empty = (cnt_ff == 3'd0);
   assign full  = (cnt_ff > 3'd2);
   assign take  = pop && !empty;
   assign head  = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff + 2'(wr.wr0) + 2'(wr.wr1);
      rp_in  = rp_ff + 2'(take);
      cnt_in = cnt_ff + 3'(wr.wr0) + 3'(wr.wr1) - 3'(take);
   end

   always_ff @(posedge clock) begin
      if (wr.wr0) mem_ff[wp_ff] <= rec0;
      if (wr.wr1) mem_ff[wp_ff + 2'd1] <= rec1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/script_token_scanner_core.sv =====
// ----------------------------------------------------------------------------
// script_token_scanner_core
// byte-serial tokenizer for a small script language
// ----------------------------------------------------------------------------
// One source byte is taken per clock (push while full is low); each request
// is scanned in the cycle it is accepted and yields zero, one or two token
// records (kind, keyword or symbol code, row, start column, length, last).
// Records wait in a four-deep queue and come out oldest first while empty is
// low, one per pop. full rises while fewer than two slots are free, so the
// sustained rate is one byte per cycle as long as records are popped at
// least as fast as they are made; a byte that both closes one token and
// is a one-byte token of its own (or an end mark after an open token) puts
// two records in the queue, which the single pop port drains one per cycle.
// An end-of-input request closes any open token, then gives an eof record.
// ----------------------------------------------------------------------------
module script_token_scanner_core
   import sts_pkg::*;
#(
   parameter int WORD_BUF_LEN = WORD_BUF_LEN_DEF,
   parameter int COL_BITS     = COL_BITS_DEF,
   parameter int ROW_BITS     = ROW_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // request side
   input  logic [7:0]          req_ch,
   input  logic                req_at_end,
   input  logic                push,
   output logic                full,
   // record side
   output logic [3:0]          rsp_token_kind,
   output logic [4:0]          rsp_keyword_code,
   output logic [4:0]          rsp_symbol_code,
   output logic [ROW_BITS-1:0] rsp_row,
   output logic [COL_BITS-1:0] rsp_start_col,
   output logic [COL_BITS-1:0] rsp_length,
   output logic                rsp_last,
   output logic                empty,
   input  logic                pop
);

   // record layout: kind, keyword, symbol, row, start, length, last
   localparam int REC_W = 4 + 5 + 5 + ROW_BITS + 2 * COL_BITS + 1;

   logic             accept;
   push_type         wr;
   logic [REC_W-1:0] rec0, rec1, head;

   // a request is taken whenever the queue has room for two records
   assign accept = push && !full;

   sts_front #(
      .WORD_BUF_LEN (WORD_BUF_LEN),
      .COL_BITS     (COL_BITS),
      .ROW_BITS     (ROW_BITS),
      .REC_W        (REC_W)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .ch     (req_ch),
      .at_end (req_at_end),
      .wr     (wr),
      .rec0   (rec0),
      .rec1   (rec1)
   );

   sts_queue #(
      .REC_W (REC_W)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .rec0  (rec0),
      .rec1  (rec1),
      .pop   (pop),
      .full  (full),
      .empty (empty),
      .head  (head)
   );

   // unpack the oldest record onto the ports
   assign rsp_token_kind   = head[REC_W-1 -: 4];
   assign rsp_keyword_code = head[REC_W-5 -: 5];
   assign rsp_symbol_code  = head[REC_W-10 -: 5];
   assign rsp_row          = head[2*COL_BITS+ROW_BITS : 2*COL_BITS+1];
   assign rsp_start_col    = head[2*COL_BITS : COL_BITS+1];
   assign rsp_length       = head[COL_BITS : 1];
   assign rsp_last         = head[0];

endmodule
